@@ hw/rtl/url_percent_decoder_defines.svh @@
// Assertion macros shared by the URL percent decoder RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef URL_PERCENT_DECODER_DEFINES_SVH
`define URL_PERCENT_DECODER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define UPD_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define UPD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/upd_pkg.sv @@
// Types, constants and the hex digit decoder shared by the URL percent decoder.
// No dependencies.
package upd_pkg;

   localparam logic [7:0] PERCENT_CHAR = 8'h25;
   localparam int         JOB_SLOTS    = 3;

   typedef enum logic [1:0] {
      PHASE_IDLE = 2'd0,
      PHASE_PCT  = 2'd1,
      PHASE_HIGH = 2'd2
   } phase_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] nib;
   } hex_type;

   // one to three decoded bytes caused by one input word, bytes[0] goes first
   typedef struct packed {
      logic [1:0]                cnt;
      logic [JOB_SLOTS-1:0][7:0] bytes;
      logic                      last;
   } job_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type r;
      r.ok  = 1'b1;
      r.nib = 4'd0;
      if (c inside {[8'h30:8'h39]}) begin
         r.nib = c[3:0];
      end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
         r.nib = c[3:0] + 4'd9;
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/upd_front.sv @@
// Front end: accepts input words, tracks the escape phase, builds output jobs.
// Depends on upd_pkg.
module upd_front import upd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_in,
   input  logic       req_end_of_string,
   input  logic       queue_full,
   output logic       push,
   output job_type    push_job
);

   phase_type  phase_ff, phase_in, phase_step;
   logic [7:0] held_ff, held_in, held_step;
   hex_type    cur_hex, held_hex;
   logic       accept, opens;
   job_type    job;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign cur_hex   = hex_decode(req_char_in);
   assign held_hex  = hex_decode(held_ff);
   assign opens     = (req_char_in == PERCENT_CHAR) && !req_end_of_string;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_IDLE;
         held_ff  <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

   always_comb begin
      phase_step = PHASE_IDLE;
      held_step  = held_ff;
      job        = '0;
      case (phase_ff)
         PHASE_PCT: begin
            if (cur_hex.ok) begin
               if (req_end_of_string) begin
                  job.cnt      = 2'd2;
                  job.bytes[0] = PERCENT_CHAR;
                  job.bytes[1] = req_char_in;
                  job.last     = 1'b1;
               end else begin
                  held_step  = req_char_in;
                  phase_step = PHASE_HIGH;
               end
            end else if (opens) begin
               job.cnt      = 2'd1;
               job.bytes[0] = PERCENT_CHAR;
               phase_step   = PHASE_PCT;
            end else begin
               job.cnt      = 2'd2;
               job.bytes[0] = PERCENT_CHAR;
               job.bytes[1] = req_char_in;
               job.last     = req_end_of_string;
            end
         end
         PHASE_HIGH: begin
            if (cur_hex.ok && held_hex.ok) begin
               job.cnt      = 2'd1;
               job.bytes[0] = {held_hex.nib, cur_hex.nib};
               job.last     = req_end_of_string;
            end else if (opens) begin
               job.cnt      = 2'd2;
               job.bytes[0] = PERCENT_CHAR;
               job.bytes[1] = held_ff;
               phase_step   = PHASE_PCT;
            end else begin
               job.cnt      = 2'd3;
               job.bytes[0] = PERCENT_CHAR;
               job.bytes[1] = held_ff;
               job.bytes[2] = req_char_in;
               job.last     = req_end_of_string;
            end
         end
         default: begin
            if (opens) begin
               phase_step = PHASE_PCT;
            end else begin
               job.cnt      = 2'd1;
               job.bytes[0] = req_char_in;
               job.last     = req_end_of_string;
            end
         end
      endcase
      phase_in = accept ? phase_step : phase_ff;
      held_in  = accept ? held_step  : held_ff;
   end

   assign push     = accept && (job.cnt != 2'd0);
   assign push_job = job;

endmodule

@@ hw/rtl/upd_queue.sv @@
// Short job queue between the front end and the output sequencer.
// Depends on upd_pkg and url_percent_decoder_defines.svh.
module upd_queue import upd_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

`include "url_percent_decoder_defines.svh"

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type            mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full       = count_ff == CNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_job   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   `UPD_ASSERT_IMP(a_no_push_full, full, !push, "job pushed into full queue")
   `UPD_ASSERT_IMP(a_no_pop_empty, pop, head_valid, "job popped from empty queue")
   `UPD_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH), "queue count overflow")

endmodule

@@ hw/rtl/upd_back.sv @@
// Output sequencer: walks the head job one byte per word into the rsp register.
// Depends on upd_pkg and url_percent_decoder_defines.svh.
module upd_back import upd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  job_type    head_job,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_char_out,
   output logic       rsp_last_out
);

`include "url_percent_decoder_defines.svh"

   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic [1:0] idx_ff, idx_in;
   logic       load, last_byte;

   assign load      = head_valid && (!valid_ff || !rsp_stall);
   assign last_byte = idx_ff == (head_job.cnt - 2'd1);
   assign pop       = load && last_byte;

   always_comb begin
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      if (!valid_ff || !rsp_stall) begin
         valid_in = head_valid;
      end
      if (load) begin
         char_in = head_job.bytes[idx_ff];
         last_in = last_byte && head_job.last;
         idx_in  = last_byte ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_char_out = char_ff;
   assign rsp_last_out = last_ff;

   `UPD_ASSERT_IMP(a_idx_in_job, head_valid, idx_ff < head_job.cnt, "byte index past job")
   `UPD_ASSERT_IMP(a_idx_needs_job, idx_ff != 2'd0, head_valid, "partial job without head")
   `UPD_ASSERT_NEXT(a_pop_rewinds, pop, idx_ff == 2'd0, "byte index not rewound on pop")

endmodule

@@ hw/rtl/url_percent_decoder.sv @@
// URL percent decoder top level: front end, job queue, output sequencer.
// Depends on upd_pkg, upd_front, upd_queue, upd_back.
//
//   channel | direction | fields                         | handshake
//   req     | in        | char_in[7:0], end_of_string    | req_valid / req_stall
//   rsp     | out       | char_out[7:0], last_out        | rsp_valid / rsp_stall
//
// One input word per cycle while req_stall is low; a word yields zero to three output words.
// The output register sends one word per cycle while rsp_stall is low, so multi-byte jobs hold it.
// An accepted word's job passes through the job queue, then the output register.
// Queue holds QUEUE_DEPTH jobs; req_stall is high while the job queue is full.
// Reset is synchronous and clears the escape phase, the queue and the output valid flag.
module url_percent_decoder import upd_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_in,
   input  logic       req_end_of_string,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_char_out,
   output logic       rsp_last_out
);

   logic    queue_full, push, pop, head_valid;
   job_type push_job, head_job;

   upd_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_char_in       (req_char_in),
      .req_end_of_string (req_end_of_string),
      .queue_full        (queue_full),
      .push              (push),
      .push_job          (push_job)
   );

   upd_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   upd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head_job     (head_job),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_char_out (rsp_char_out),
      .rsp_last_out (rsp_last_out)
   );

endmodule

@@ verif/url_percent_decoder_tb.sv @@
// Self-checking testbench for url_percent_decoder: directed strings, then random strings under varying
// valid/stall traffic, checked against an in-bench percent-decode predictor or typed per-row expectations.
// Depends on upd_pkg and the url_percent_decoder RTL.
module url_percent_decoder_tb import upd_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_WORDS  = 95;
   localparam int DIR_ROWS     = 24;
   localparam int PRINT_LIMIT  = 30;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } dec_byte_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       eos;
      logic       typed;
      logic [7:0] exp_ch;
      logic       exp_last;
   } dir_row_type;

   logic       clock             = 1'b0;
   logic       reset             = 1'b1;
   logic       req_valid         = 1'b0;
   logic       req_stall;
   logic [7:0] req_char_in       = 8'h00;
   logic       req_end_of_string = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall         = 1'b0;
   logic [7:0] rsp_char_out;
   logic       rsp_last_out;

   // decoder shadow state
   phase_type  esc_phase  = PHASE_IDLE;
   logic [7:0] held_digit = 8'h00;

   dec_byte_type  pending_bytes[$];
   dec_byte_type  step_bytes[$];

   int idle_pct      = 0;
   int stall_pct     = 0;
   int words_sent    = 0;
   int strings_sent  = 0;
   int bytes_checked = 0;
   int err_count     = 0;
   int cycle_count   = 0;

   // expected values only on rows whose result is obvious; the rest go through the predictor
   dir_row_type dir_rows [DIR_ROWS] = '{
      '{8'h41,        1'b0, 1'b1, 8'h41, 1'b0},
      '{8'h00,        1'b0, 1'b1, 8'h00, 1'b0},
      '{PERCENT_CHAR, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'h66,        1'b0, 1'b0, 8'h00, 1'b0},
      '{8'h46,        1'b0, 1'b0, 8'h00, 1'b0},
      '{PERCENT_CHAR, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'h47,        1'b0, 1'b0, 8'h00, 1'b0},
      '{PERCENT_CHAR, 1'b0, 1'b0, 8'h00, 1'b0},
      '{PERCENT_CHAR, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'h34,        1'b0, 1'b0, 8'h00, 1'b0},
      '{8'h31,        1'b0, 1'b0, 8'h00, 1'b0},
      '{PERCENT_CHAR, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'h34,        1'b0, 1'b0, 8'h00, 1'b0},
      '{8'h7A,        1'b0, 1'b0, 8'h00, 1'b0},
      '{PERCENT_CHAR, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'h62,        1'b0, 1'b0, 8'h00, 1'b0},
      '{PERCENT_CHAR, 1'b1, 1'b0, 8'h00, 1'b0},
      '{PERCENT_CHAR, 1'b1, 1'b0, 8'h00, 1'b0},
      '{PERCENT_CHAR, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'h61,        1'b0, 1'b0, 8'h00, 1'b0},
      '{8'h39,        1'b1, 1'b0, 8'h00, 1'b0},
      '{PERCENT_CHAR, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'h42,        1'b1, 1'b0, 8'h00, 1'b0},
      '{8'hFF,        1'b1, 1'b1, 8'hFF, 1'b1}
   };

   logic [7:0] edge_chars [6] = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67};

   url_percent_decoder u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_char_in       (req_char_in),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_char_out      (rsp_char_out),
      .rsp_last_out      (rsp_last_out)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int hex_nibble(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
      if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
      if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
      return -1;
   endfunction

   function automatic void emit_byte(input logic [7:0] c, input logic last);
      step_bytes.push_back('{ch: c, last: last});
   endfunction

   // character seen as if no escape were pending
   function automatic void restart_char(input logic [7:0] c, input logic eos);
      if (c == PERCENT_CHAR && !eos) begin
         esc_phase = PHASE_PCT;
      end else begin
         esc_phase = PHASE_IDLE;
         emit_byte(c, eos);
      end
   endfunction

   function automatic void decode_step(input logic [7:0] c, input logic eos);
      int v;
      int hv;
      v = hex_nibble(c);
      case (esc_phase)
         PHASE_PCT: begin
            if (v >= 0) begin
               if (eos) begin
                  emit_byte(PERCENT_CHAR, 1'b0);
                  emit_byte(c, 1'b1);
                  esc_phase = PHASE_IDLE;
               end else begin
                  held_digit = c;
                  esc_phase  = PHASE_HIGH;
               end
            end else begin
               emit_byte(PERCENT_CHAR, 1'b0);
               restart_char(c, eos);
            end
         end
         PHASE_HIGH: begin
            hv = hex_nibble(held_digit);
            if (v >= 0 && hv >= 0) begin
               esc_phase = PHASE_IDLE;
               emit_byte({hv[3:0], v[3:0]}, eos);
            end else begin
               emit_byte(PERCENT_CHAR, 1'b0);
               emit_byte(held_digit, 1'b0);
               restart_char(c, eos);
            end
         end
         default: begin
            restart_char(c, eos);
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      err_count++;
      if (err_count <= PRINT_LIMIT) $display("ERROR @%0t: %s", $realtime, what);
   endtask

   task automatic send_word(input logic [7:0] c, input logic eos, input logic typed,
                            input dec_byte_type typed_exp);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_char_in       <= c;
      req_end_of_string <= eos;
      do @(posedge clock); while (req_stall);
      step_bytes.delete();
      decode_step(c, eos);
      if (typed) pending_bytes.push_back(typed_exp);
      else foreach (step_bytes[i]) pending_bytes.push_back(step_bytes[i]);
      words_sent++;
      if (eos) strings_sent++;
   endtask

   function automatic logic [7:0] pick_hex();
      int r;
      r = $urandom_range(21);
      if (r < 10) return 8'h30 + r[7:0];
      if (r < 16) return 8'h61 + r[7:0] - 8'd10;
      return 8'h41 + r[7:0] - 8'd16;
   endfunction

   function automatic logic [7:0] pick_non_hex();
      logic [7:0] c;
      if ($urandom_range(1) == 0) return edge_chars[$urandom_range(5)];
      do c = 8'($urandom_range(255)); while (hex_nibble(c) >= 0);
      return c;
   endfunction

   // mostly well-formed escapes and plain bytes, some broken escapes, some cut at the end
   task automatic send_random_string();
      logic [7:0]    chars[$];
      int            len;
      int            kind;
      dec_byte_type  none;
      none = '0;
      len  = $urandom_range(1, 10);
      repeat (len) begin
         kind = $urandom_range(99);
         if (kind < 45) begin
            chars.push_back(PERCENT_CHAR);
            chars.push_back(pick_hex());
            chars.push_back(pick_hex());
         end else if (kind < 80) begin
            chars.push_back(8'($urandom_range(255)));
         end else if (kind < 90) begin
            chars.push_back(PERCENT_CHAR);
            chars.push_back(pick_non_hex());
         end else begin
            chars.push_back(PERCENT_CHAR);
            chars.push_back(pick_hex());
            chars.push_back(pick_non_hex());
         end
      end
      kind = $urandom_range(99);
      if (kind < 10) begin
         chars.push_back(PERCENT_CHAR);
      end else if (kind < 20) begin
         chars.push_back(PERCENT_CHAR);
         chars.push_back(pick_hex());
      end
      foreach (chars[i]) send_word(chars[i], i == chars.size() - 1, 1'b0, none);
   endtask

   task automatic wait_drained();
      while (pending_bytes.size() != 0) @(posedge clock);
   endtask

   // response side: check accepted words, then pick next stall
   initial begin
      dec_byte_type exp_b;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_bytes.size() == 0) begin
               report_mismatch($sformatf("unexpected word char=%02h last=%b",
                                         rsp_char_out, rsp_last_out));
            end else begin
               exp_b = pending_bytes.pop_front();
               if (rsp_char_out !== exp_b.ch)
                  report_mismatch($sformatf("char_out %02h, expected %02h",
                                            rsp_char_out, exp_b.ch));
               if (rsp_last_out !== exp_b.last)
                  report_mismatch($sformatf("last_out %b, expected %b (char %02h)",
                                            rsp_last_out, exp_b.last, exp_b.ch));
               bytes_checked++;
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("url_percent_decoder_tb NOT OK");
      $finish;
   end

   initial begin
      int idle_tab [4];
      int stall_tab [4];
      int goal;
      idle_tab  = '{0, 47, 0, 22};
      stall_tab = '{0, 0, 47, 22};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         send_word(dir_rows[i].ch, dir_rows[i].eos, dir_rows[i].typed,
                   '{ch: dir_rows[i].exp_ch, last: dir_rows[i].exp_last});
      end

      goal = words_sent;
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct  = idle_tab[ph];
         stall_pct = stall_tab[ph];
         goal      = goal + PHASE_WORDS;
         while (words_sent < goal) send_random_string();
         if (ph == 1) begin
            req_valid <= 1'b0;
            wait_drained();
         end
      end

      req_valid <= 1'b0;
      wait_drained();
      repeat (20) @(posedge clock);

      $display("sent %0d words in %0d strings, checked %0d decoded words",
               words_sent, strings_sent, bytes_checked);
      $display("traffic: free-running, sender gaps, receiver stalls, both; one full drain");
      if (err_count == 0) begin
         $display("url_percent_decoder_tb OK");
      end else begin
         $display("url_percent_decoder_tb NOT OK");
      end
      $finish;
   end

endmodule
